[rtl/core/drgs_pkg.sv]
package drgs_pkg;

    localparam int unsigned DEPTH_W = 16;
    localparam int unsigned DRAFT_W = 14;
    localparam int unsigned GRADE_W = 3;
    localparam int unsigned NUM_GRADES = 8;
    localparam int unsigned WINS_PER_GRADE = 6;

    typedef logic [DEPTH_W-1:0] t_depth;
    typedef logic [DRAFT_W-1:0] t_draft;
    typedef logic [GRADE_W-1:0] t_grade;

    localparam t_draft DRAFT_RESET    = 14'd50;
    localparam t_grade GRADE_NONE     = 3'd0;
    localparam t_grade GRADE_NO_WATER = 3'd3;

    // One depth window: open at both ends; from_draft takes the lower bound from draft_cm
    typedef struct packed {
        t_grade to;
        logic   from_draft;
        t_depth lower;
        t_depth upper;
    } t_window;

    localparam t_window WIN_TABLE [NUM_GRADES][WINS_PER_GRADE] = '{
        '{ '{3'd1, 1'b1, 16'd0,     16'd500},   '{3'd2, 1'b0, 16'd650,   16'd1400},
           '{3'd3, 1'b0, 16'd1300,  16'd2900},  '{3'd4, 1'b0, 16'd2700,  16'd5900},
           '{3'd5, 1'b0, 16'd5800,  16'd11000}, '{3'd6, 1'b0, 16'd10000, 16'd23000} },
        '{ '{3'd2, 1'b0, 16'd650,   16'd1400},  '{3'd3, 1'b0, 16'd1300,  16'd2900},
           '{3'd4, 1'b0, 16'd2700,  16'd5900},  '{3'd5, 1'b0, 16'd5800,  16'd11000},
           '{3'd6, 1'b0, 16'd11000, 16'd23000}, '{3'd7, 1'b0, 16'd23000, 16'd30000} },
        '{ '{3'd1, 1'b1, 16'd0,     16'd500},   '{3'd3, 1'b0, 16'd1300,  16'd2900},
           '{3'd4, 1'b0, 16'd2700,  16'd5900},  '{3'd5, 1'b0, 16'd5800,  16'd11000},
           '{3'd6, 1'b0, 16'd11000, 16'd23000}, '{3'd7, 1'b0, 16'd23000, 16'd30000} },
        '{ '{3'd1, 1'b1, 16'd0,     16'd700},   '{3'd2, 1'b0, 16'd600,   16'd1200},
           '{3'd4, 1'b0, 16'd2700,  16'd5900},  '{3'd5, 1'b0, 16'd5800,  16'd11000},
           '{3'd6, 1'b0, 16'd11000, 16'd23000}, '{3'd7, 1'b0, 16'd23000, 16'd30000} },
        '{ '{3'd1, 1'b1, 16'd0,     16'd700},   '{3'd2, 1'b0, 16'd600,   16'd1400},
           '{3'd3, 1'b0, 16'd1300,  16'd2600},  '{3'd5, 1'b0, 16'd5800,  16'd11000},
           '{3'd6, 1'b0, 16'd11000, 16'd23000}, '{3'd7, 1'b0, 16'd23000, 16'd30000} },
        '{ '{3'd1, 1'b1, 16'd0,     16'd700},   '{3'd2, 1'b0, 16'd600,   16'd1400},
           '{3'd3, 1'b0, 16'd1300,  16'd2700},  '{3'd4, 1'b0, 16'd2600,  16'd5600},
           '{3'd6, 1'b0, 16'd11000, 16'd23000}, '{3'd7, 1'b0, 16'd23000, 16'd30000} },
        '{ '{3'd1, 1'b1, 16'd0,     16'd700},   '{3'd2, 1'b0, 16'd600,   16'd1400},
           '{3'd3, 1'b0, 16'd1300,  16'd2700},  '{3'd4, 1'b0, 16'd2600,  16'd5800},
           '{3'd5, 1'b0, 16'd5700,  16'd10000}, '{3'd7, 1'b0, 16'd23000, 16'd30000} },
        '{ '{3'd1, 1'b1, 16'd0,     16'd700},   '{3'd2, 1'b0, 16'd600,   16'd1400},
           '{3'd3, 1'b0, 16'd1300,  16'd2700},  '{3'd4, 1'b0, 16'd2600,  16'd5800},
           '{3'd5, 1'b0, 16'd5700,  16'd10000}, '{3'd6, 1'b0, 16'd11000, 16'd23000} }
    };

    // Extra lowest-priority window that only grade 0 checks
    localparam t_window GRADE0_LAST = '{3'd7, 1'b0, 16'd22000, 16'd30000};

endpackage

[rtl/core/drgs_grade_logic.sv]
module drgs_grade_logic (
    input  drgs_pkg::t_depth i_depth_cm,
    input  drgs_pkg::t_draft i_draft_cm,
    input  drgs_pkg::t_grade i_cur_grade,
    output drgs_pkg::t_grade o_next_grade
);
    import drgs_pkg::*;

    t_depth  draft_ext;
    t_window win;
    t_depth  lo;
    logic    found;

    assign draft_ext = {{(DEPTH_W-DRAFT_W){1'b0}}, i_draft_cm};

    // Scan the windows of the current grade, first hit wins
    always_comb begin
        o_next_grade = i_cur_grade;
        found        = 1'b0;
        win          = WIN_TABLE[0][0];
        lo           = '0;
        for (int i = 0; i < WINS_PER_GRADE; i++) begin
            win = WIN_TABLE[i_cur_grade][i];
            lo  = win.from_draft ? draft_ext : win.lower;
            if (!found && (i_depth_cm > lo) && (i_depth_cm < win.upper)) begin
                o_next_grade = win.to;
                found        = 1'b1;
            end
        end
        // Grade 0 fallbacks: last deep window, then depth at the draft
        if (!found && (i_cur_grade == GRADE_NONE)) begin
            if ((i_depth_cm > GRADE0_LAST.lower) &&
                (i_depth_cm < GRADE0_LAST.upper)) begin
                o_next_grade = GRADE0_LAST.to;
            end else if (i_depth_cm == draft_ext) begin
                o_next_grade = GRADE_NO_WATER;
            end
        end
    end

endmodule

[rtl/core/depth_range_grade_selector.sv]
// Depth range grade selector. Each accepted depth (cm) yields one result: the
// range grade 0..7 (0 = none chosen yet, the value after reset) and a flag that
// is set when the grade changed, through the input then the result register.
// One depth per cycle unless the result stalls (single grade register feeds the
// window compare). The draft register (reset 50 cm, own always-ready port) must
// be written only while idle; the block itself does not enforce that.
module depth_range_grade_selector (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // depth input channel
    input  logic             i_valid,
    output logic             o_stall,
    input  drgs_pkg::t_depth i_depth_cm,
    // result channel
    output logic             o_valid,
    input  logic             i_stall,
    output drgs_pkg::t_grade o_grade,
    output logic             o_grade_changed,
    // draft register write
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  drgs_pkg::t_draft i_cfg_draft_cm
);
    import drgs_pkg::*;

    t_draft r_draft;
    t_grade r_grade;
    logic   r_in_valid;
    t_depth r_depth;
    logic   r_out_valid;
    t_grade r_out_grade;
    logic   r_out_changed;

    t_grade n_grade;
    logic   out_free;
    logic   advance;

    assign o_cfg_ready = 1'b1;

    // Draft register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draft <= DRAFT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_draft <= i_cfg_draft_cm;
        end
    end

    // Pipeline flow control
    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_depth <= i_depth_cm;
        end
    end

    drgs_grade_logic u_grade_logic (
        .i_depth_cm  (r_depth),
        .i_draft_cm  (r_draft),
        .i_cur_grade (r_grade),
        .o_next_grade(n_grade)
    );

    // Grade state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grade     <= GRADE_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_grade <= n_grade;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_grade   <= n_grade;
            r_out_changed <= (n_grade != r_grade);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_grade         = r_out_grade;
    assign o_grade_changed = r_out_changed;

    // Checks
    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_grade == r_grade))
        else $error("result grade differs from grade state");

    a_changed_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (o_grade_changed == (o_grade != $past(r_grade))))
        else $error("change flag inconsistent with grade update");

    a_no_return_to_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_grade != GRADE_NONE) |=> (r_grade != GRADE_NONE))
        else $error("grade fell back to none");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with free pipeline");

endmodule
